// File: hw/rtl/spif_pkg.sv
// Shared types and constants for the single-pole IIR filter.
// No dependencies; every other file of the block imports this package.
package spif_pkg;

	localparam int SAMPLE_W = 16;                 // input sample width
	localparam int REG_W    = 16;                 // configuration register width
	localparam int ACC_W    = 32;                 // accumulator and output width
	localparam int PROD_W   = SAMPLE_W + REG_W + 2; // full signed product width
	localparam int MAG_W    = ACC_W + 1;          // magnitude of the difference
	localparam int DIV_STEPS = MAG_W;             // one quotient bit per cycle
	localparam int CNT_W    = $clog2(DIV_STEPS + 1);
	localparam int IDX_W    = 1;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_SCALE   = 1'b0,
		REG_DIVISOR = 1'b1
	} reg_idx_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIFF,
		S_DIV,
		S_WRITE
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture sample and effective registers
		logic mul;    // register the scaled sample
		logic diff;   // form the difference and start the divider
		logic commit; // update accumulator and output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_busy;
	} dp_status_t;

endpackage

// File: hw/rtl/single_pole_iir_filter.sv
// Single-pole integer IIR filter (exponential moving average), top level.
// Depends on spif_pkg, spif_ctrl, spif_dp and spif_div.
//
// Usage:
//   Input channel: sample with in_valid / in_stall. A beat is taken when
//   in_valid is high and in_stall is low. Output channel: filtered with
//   out_valid / out_stall, taken when out_valid is high and out_stall low.
//   Config port: cfg_we, cfg_index (0 = scale, 1 = smoothing_divisor),
//   cfg_data; write only while no sample is in flight.
// Sequence:
//   One sample at a time. After a beat is taken it passes through the
//   multiply step, the difference step, the bit-serial divider (which
//   yields the quotient one bit at a time), a step to see the divider
//   finish and the commit step. A new sample is taken the cycle after
//   commit; the serial divider takes most of the time per sample.
// Reset: registers return to 1, the filter is unprimed, no output beat.
// Stall: the result stays in the output register; the next sample is
//   still taken and processed, and waits to commit until the slot frees.
module single_pole_iir_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [spif_pkg::IDX_W-1:0]           cfg_index,
	input  logic [spif_pkg::REG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [spif_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [spif_pkg::ACC_W-1:0]    filtered
);
	import spif_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	spif_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	spif_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.cmd       (cmd),
		.status    (status),
		.filtered  (filtered)
	);

endmodule

// File: hw/rtl/spif_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on spif_pkg for widths.
module spif_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spif_pkg::MAG_W-1:0]    dividend,
	input  logic [spif_pkg::REG_W-1:0]    divisor,
	output logic                          busy,
	output logic [spif_pkg::MAG_W-1:0]    quotient
);
	import spif_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REG_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [REG_W:0]   trial;
	logic             fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign fits  = (trial >= {1'b0, divisor});

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? REG_W'(trial - {1'b0, divisor}) : trial[REG_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// File: hw/rtl/spif_dp.sv
// Datapath of the single-pole IIR filter: registers, multiply, difference,
// divider and accumulator. Depends on spif_pkg and spif_div.
module spif_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [spif_pkg::IDX_W-1:0]        cfg_index,
	input  logic [spif_pkg::REG_W-1:0]        cfg_data,
	input  logic signed [spif_pkg::SAMPLE_W-1:0] sample,
	input  spif_pkg::ctrl_cmd_t               cmd,
	output spif_pkg::dp_status_t              status,
	output logic signed [spif_pkg::ACC_W-1:0] filtered
);
	import spif_pkg::*;

	logic [REG_W-1:0]           scale_q;
	logic [REG_W-1:0]           divisor_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [REG_W-1:0]           scale_eff_q;
	logic [REG_W-1:0]           k_eff_q;
	logic signed [PROD_W-1:0]   prod_full;
	logic [ACC_W-1:0]           prod_q;
	logic                       primed_q;
	logic [ACC_W-1:0]           acc_q;
	logic [ACC_W-1:0]           base;
	logic [ACC_W-1:0]           base_q;
	logic [MAG_W-1:0]           diff;
	logic [MAG_W-1:0]           mag;
	logic                       neg_q;
	logic                       div_busy;
	logic [MAG_W-1:0]           quo;
	logic [MAG_W-1:0]           step;
	logic [ACC_W-1:0]           acc_new;
	logic [ACC_W-1:0]           filtered_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= REG_W'(1);
			divisor_q <= REG_W'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SCALE:   scale_q   <= cfg_data;
				REG_DIVISOR: divisor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the sample and the effective scale and divisor
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q    <= sample;
			scale_eff_q <= (scale_q == '0) ? REG_W'(1) : scale_q;
			k_eff_q     <= (divisor_q == '0) ? REG_W'(1) : divisor_q;
		end
	end

	// Scale the sample; the product always fits the accumulator width
	assign prod_full = sample_q * $signed({1'b0, scale_eff_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod_full[ACC_W-1:0];
		end
	end

	// First sample loads the accumulator with the scaled input
	assign base = primed_q ? acc_q : prod_q;
	assign diff = {prod_q[ACC_W-1], prod_q} - {base[ACC_W-1], base};
	assign mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			base_q <= base;
			neg_q  <= diff[MAG_W-1];
		end
	end

	spif_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.diff),
		.dividend (mag),
		.divisor  (k_eff_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	// Restore the sign of the truncated quotient and add it in
	assign step    = neg_q ? (~quo + MAG_W'(1)) : quo;
	assign acc_new = base_q + step[ACC_W-1:0];

	// Filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			acc_q    <= '0;
		end else if (cmd.commit) begin
			primed_q <= 1'b1;
			acc_q    <= acc_new;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			filtered_q <= acc_new;
		end
	end

	assign status.div_busy = div_busy;
	assign filtered        = $signed(filtered_q);

endmodule

// File: hw/rtl/spif_ctrl.sv
// Controller of the single-pole IIR filter: sequences one sample through
// the datapath and owns both handshakes. Depends on spif_pkg.
module spif_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output spif_pkg::ctrl_cmd_t  cmd,
	input  spif_pkg::dp_status_t status
);
	import spif_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	// Output register is free when empty or being taken this cycle
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				if (!status.div_busy) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.commit || (out_valid_q && out_stall);
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("result committed over an untaken beat");
	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_MUL))
		else $error("accepted beat did not enter the multiply step");
	a_rose_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_WRITE))
		else $error("output raised outside the write step");
`endif

endmodule

// File: dv/single_pole_iir_filter_tb.sv
// Self-checking testbench for single_pole_iir_filter: directed and random samples.
// Predicts every filtered beat with its own integer model and checks each accepted beat.
// Depends on spif_pkg and the single_pole_iir_filter RTL.
module single_pole_iir_filter_tb;
	import spif_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int SETTLE_CYCLES = 45;      // a bit more than one sample's latency
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MAX_GAP      = 45;       // longest sender gap, spans a whole divide

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [IDX_W-1:0]           cfg_index = '0;
	logic [REG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [ACC_W-1:0]    filtered;

	// Filter model state
	logic [REG_W-1:0] ema_scale = 16'd1;
	logic [REG_W-1:0] ema_divisor = 16'd1;
	bit               ema_primed = 1'b0;
	longint           ema_acc = 0;

	logic signed [ACC_W-1:0] expected_filtered[$];
	int unsigned             fail_count = 0;
	int unsigned             cycle_count = 0;
	int unsigned             sender_idle_pct = 0;
	int unsigned             recv_stall_pct = 0;

	single_pole_iir_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.filtered  (filtered)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Advance the filter model by one sample and return the new accumulator
	function automatic logic signed [ACC_W-1:0] ema_update(logic signed [SAMPLE_W-1:0] x);
		longint s_eff;
		longint k_eff;
		longint scaled;
		s_eff = (ema_scale == 0) ? 1 : longint'(ema_scale);
		k_eff = (ema_divisor == 0) ? 1 : longint'(ema_divisor);
		scaled = longint'(x) * s_eff;
		if (!ema_primed) begin
			ema_primed = 1'b1;
			ema_acc = scaled;
		end
		// signed longint division truncates toward zero
		ema_acc = ema_acc + (scaled - ema_acc) / k_eff;
		return ema_acc[ACC_W-1:0];
	endfunction

	// Predict on each input beat, track register writes, check each output beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_filtered.push_back(ema_update(sample));
			if (cfg_we) begin
				if (cfg_index == REG_SCALE)
					ema_scale = cfg_data;
				else if (cfg_index == REG_DIVISOR)
					ema_divisor = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_filtered.size() == 0) begin
					$error("unexpected output beat: filtered %0d", filtered);
					fail_count++;
				end else begin
					logic signed [ACC_W-1:0] want;
					want = expected_filtered.pop_front();
					if (filtered !== want) begin
						$error("filtered mismatch: expected %0d, actual %0d", want, filtered);
						fail_count++;
					end
				end
			end
		end
	end

	// Stall the output side in the chosen share of cycles
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Send one sample beat; entered and left at a falling edge
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		int unsigned gap;
		if ($urandom_range(99) < sender_idle_pct) begin
			gap = $urandom_range(MAX_GAP, 1);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		sample = value;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Hold off the sender until every expected beat has come, then let the block settle
	task automatic drain_results();
		in_valid = 1'b0;
		while (expected_filtered.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_filter_regs(input logic [REG_W-1:0] scale_val,
			input logic [REG_W-1:0] divisor_val);
		drain_results();
		write_reg(REG_SCALE, scale_val);
		write_reg(REG_DIVISOR, divisor_val);
	endtask

	// First beat after reset loads the accumulator, reset registers pass through
	task automatic test_priming();
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		send_sample(16'sd0);
	endtask

	// Largest scale with the extremes of the sample
	task automatic test_product_extremes();
		set_filter_regs(16'hFFFF, 16'd1);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(-16'sd1);
		send_sample(16'sd1);
	endtask

	// A zero scale acts as one
	task automatic test_zero_scale();
		set_filter_regs(16'd0, 16'd1);
		send_sample(16'sd5);
		send_sample(-16'sd7);
	endtask

	// A zero divisor acts as one
	task automatic test_zero_divisor();
		set_filter_regs(16'd3, 16'd0);
		send_sample(16'sd100);
		send_sample(-16'sd100);
	endtask

	// Heavy and light smoothing, truncation of negative steps toward zero
	task automatic test_smoothing();
		set_filter_regs(16'hFFFF, 16'hFFFF);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(-16'sd32768);
		set_filter_regs(16'hFFFF, 16'd2);
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		send_sample(16'sd32767);
		set_filter_regs(16'd1, 16'd3);
		send_sample(-16'sd1);
		send_sample(-16'sd2);
	endtask

	// New registers apply from the next sample; the accumulator keeps its scale
	task automatic test_register_change();
		set_filter_regs(16'd10, 16'd4);
		send_sample(16'sd1000);
		set_filter_regs(16'd1, 16'd4);
		send_sample(16'sd1000);
	endtask

	function automatic logic [REG_W-1:0] pick_scale();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			default: return REG_W'($urandom);
		endcase
	endfunction

	function automatic logic [REG_W-1:0] pick_divisor();
		case ($urandom_range(6))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3, 4: return REG_W'($urandom_range(16, 2));
			default: return REG_W'($urandom);
		endcase
	endfunction

	// Random samples across idling phases and register settings
	task automatic test_random_traffic();
		logic signed [SAMPLE_W-1:0] x;
		int unsigned                pct_sets[4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{20, 20}};
		x = '0;
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = pct_sets[ph][0];
			recv_stall_pct = pct_sets[ph][1];
			for (int setting = 0; setting < 3; setting++) begin
				set_filter_regs(pick_scale(), pick_divisor());
				for (int n = 0; n < 62; n++) begin
					// hold the value now and then so the filter settles
					case ($urandom_range(7))
						0: x = -16'sd32768;
						1: x = 16'sd32767;
						2, 3: ;
						default: x = SAMPLE_W'($urandom);
					endcase
					send_sample(x);
					if (n == 31 && setting == 1)
						drain_results();
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		recv_stall_pct = 20;
		test_priming();
		test_product_extremes();
		test_zero_scale();
		test_zero_divisor();
		test_smoothing();
		test_register_change();
		test_random_traffic();
		drain_results();
		if (fail_count == 0 && expected_filtered.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
